@@ sv/route_table_update_lookup_defines.svh @@
// ----------------------------------------------------------------------------
// Route table update/lookup: assertion macros
// Shared property forms for the concurrent checks of the route table.
// ----------------------------------------------------------------------------
`ifndef ROUTE_TABLE_UPDATE_LOOKUP_DEFINES_SVH
`define ROUTE_TABLE_UPDATE_LOOKUP_DEFINES_SVH

// Same-cycle implication under the active-low reset.
`define RTUL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the active-low reset.
`define RTUL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rtul_pkg.sv @@
// ----------------------------------------------------------------------------
// Route table update/lookup: package
// Table geometry, entry layout, status and state codes, memory request bundle.
// ----------------------------------------------------------------------------
package rtul_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int IP_W        = 32;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic [IP_W-1:0] dest;
        logic [IP_W-1:0] hop;
        logic [IP_W-1:0] metric;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
    } mem_req_t;

endpackage

@@ sv/rtul_ram.sv @@
// ----------------------------------------------------------------------------
// Route table update/lookup: generic RAM
// One write port, one read port with a registered read.
// ----------------------------------------------------------------------------
module rtul_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/rtul_ctrl.sv @@
// ----------------------------------------------------------------------------
// Route table update/lookup: search sequencer
// Walks the live entries with a pipelined read, compares, then writes back the
// metric, appends a new entry, flags a full table or reports the lookup result.
// ----------------------------------------------------------------------------
module rtul_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     kind,
    input  logic [31:0]              dest_addr,
    input  logic [31:0]              hop_addr,
    input  logic [31:0]              route_metric,
    input  rtul_pkg::entry_t         rd_data,
    output logic                     busy,
    output rtul_pkg::mem_req_t       mem_req,
    output logic                     done,
    output rtul_pkg::status_t        status,
    output logic [31:0]              hop_out
);

    rtul_pkg::state_t                 state_reg, state_next;
    logic [rtul_pkg::COUNT_W-1:0]     idx_reg, idx_next;
    logic [rtul_pkg::ADDR_W-1:0]      pidx_reg, pidx_next;
    logic                             pend_reg, pend_next;
    logic [rtul_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic                             done_reg, done_next;
    rtul_pkg::status_t                status_reg, status_next;
    logic [31:0]                      hop_out_reg, hop_out_next;

    logic                             kind_reg;
    logic [31:0]                      dest_reg;
    logic [31:0]                      hop_reg;
    logic [31:0]                      metric_reg;
    logic                             load;
    logic                             match;
    logic                             table_full;

    assign match = pend_reg && (rd_data.dest == dest_reg) &&
                   ((kind_reg == rtul_pkg::KIND_LOOKUP) || (rd_data.hop == hop_reg));
    assign table_full = (count_reg == rtul_pkg::COUNT_W'(rtul_pkg::TABLE_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rtul_pkg::S_IDLE;
            idx_reg    <= '0;
            pidx_reg   <= '0;
            pend_reg   <= 1'b0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            pidx_reg   <= pidx_next;
            pend_reg   <= pend_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    // Item and result payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind;
            dest_reg   <= dest_addr;
            hop_reg    <= hop_addr;
            metric_reg <= route_metric;
        end
        status_reg  <= status_next;
        hop_out_reg <= hop_out_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pidx_next     = pidx_reg;
        pend_next     = pend_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        status_next   = rtul_pkg::ST_MISS;
        hop_out_next  = '0;
        load          = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.raddr = idx_reg[rtul_pkg::ADDR_W-1:0];
        mem_req.we    = 1'b0;
        mem_req.waddr = pidx_reg;
        mem_req.wdata = '{dest: dest_reg, hop: hop_reg, metric: metric_reg};

        case (state_reg)
            rtul_pkg::S_IDLE:
            begin
                if (start)
                begin
                    load       = 1'b1;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = rtul_pkg::S_SCAN;
                end
            end
            rtul_pkg::S_SCAN:
            begin
                if (match)
                begin
                    // First match ends the walk; any read in flight is dropped.
                    state_next = rtul_pkg::S_IDLE;
                    pend_next  = 1'b0;
                    done_next  = 1'b1;
                    if (kind_reg == rtul_pkg::KIND_LOOKUP)
                    begin
                        if (rd_data.hop != '0)
                        begin
                            status_next  = rtul_pkg::ST_HIT;
                            hop_out_next = rd_data.hop;
                        end
                        else
                        begin
                            status_next = rtul_pkg::ST_MISS;
                        end
                    end
                    else
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = pidx_reg;
                        status_next   = rtul_pkg::ST_UPDATED;
                    end
                end
                else if (idx_reg < count_reg)
                begin
                    mem_req.re = 1'b1;
                    pidx_next  = idx_reg[rtul_pkg::ADDR_W-1:0];
                    idx_next   = idx_reg + 1'b1;
                    pend_next  = 1'b1;
                end
                else if (pend_reg)
                begin
                    // Drain the last read.
                    pend_next = 1'b0;
                end
                else
                begin
                    state_next = rtul_pkg::S_IDLE;
                    done_next  = 1'b1;
                    if (kind_reg == rtul_pkg::KIND_LOOKUP)
                    begin
                        status_next = rtul_pkg::ST_MISS;
                    end
                    else if (!table_full)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = count_reg[rtul_pkg::ADDR_W-1:0];
                        count_next    = count_reg + 1'b1;
                        status_next   = rtul_pkg::ST_INSERTED;
                    end
                    else
                    begin
                        status_next = rtul_pkg::ST_FULL;
                    end
                end
            end
            default:
            begin
                state_next = rtul_pkg::S_IDLE;
            end
        endcase
    end

    assign busy    = (state_reg != rtul_pkg::S_IDLE);
    assign done    = done_reg;
    assign status  = status_reg;
    assign hop_out = hop_out_reg;

endmodule

@@ sv/route_table_update_lookup.sv @@
// ----------------------------------------------------------------------------
// Route table update/lookup: top level
// Exact-match routing table held in one synchronous RAM, searched linearly.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive kind, dest_addr, hop_addr and route_metric and
//   raise start; the word is taken at a clock edge where start is high and
//   busy is low. busy stays high while the table is walked.
//   Result channel: done pulses for one cycle with status and hop_out; the
//   receiver must take the word in that cycle, there is no back-pressure.
//   Search: the walk reads one entry per cycle through the RAM's single
//   read port. Throughput is one item at a time; busy falls as done
//   rises, so the next word can be taken at the edge that ends the
//   result cycle.
//   Reset: the live entry count clears to zero at once; the RAM needs no
//   clearing since only entries below the count are ever read.
// ----------------------------------------------------------------------------
`include "route_table_update_lookup_defines.svh"

module route_table_update_lookup (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [31:0] dest_addr,
    input  logic [31:0] hop_addr,
    input  logic [31:0] route_metric,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] hop_out
);

    rtul_pkg::mem_req_t mem_req;
    rtul_pkg::entry_t   rd_data;
    rtul_pkg::status_t  status_code;

    rtul_ram #(
        .WIDTH (rtul_pkg::ENTRY_W),
        .DEPTH (rtul_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rd_data)
    );

    rtul_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .dest_addr    (dest_addr),
        .hop_addr     (hop_addr),
        .route_metric (route_metric),
        .rd_data      (rd_data),
        .busy         (busy),
        .mem_req      (mem_req),
        .done         (done),
        .status       (status_code),
        .hop_out      (hop_out)
    );

    assign status = status_code;

    `RTUL_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word did not raise busy")
    `RTUL_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy, "result strobed while busy")
    `RTUL_ASSERT_NOW(a_fall_done, clk, rst_n, $fell(busy), done, "search ended without a result")
    `RTUL_ASSERT_NOW(a_hop_zero, clk, rst_n, done && (status_code != rtul_pkg::ST_HIT), hop_out == '0, "next hop reported without a hit")

endmodule

@@ tb/route_table_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route table update/lookup: result checker
// Watches the command and result channels and keeps a shadow routing table.
// Each accepted command word yields one expected result. Each strobed result
// is compared with the oldest expected one, status and next hop separately.
// ----------------------------------------------------------------------------
module route_table_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               kind,
    input  logic [31:0]        dest_addr,
    input  logic [31:0]        hop_addr,
    input  logic [31:0]        route_metric,
    input  logic               done,
    input  logic [2:0]         status,
    input  logic [31:0]        hop_out,
    output int unsigned        fail_count,
    output int unsigned        pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        rtul_pkg::status_t status;
        logic [31:0]       hop;
    } route_result_t;

    // shadow table, filled in insertion order
    logic [31:0]   shadow_dest   [rtul_pkg::TABLE_DEPTH];
    logic [31:0]   shadow_hop    [rtul_pkg::TABLE_DEPTH];
    logic [31:0]   shadow_metric [rtul_pkg::TABLE_DEPTH];
    int unsigned   shadow_count = 0;
    route_result_t route_q [$];

    function automatic route_result_t resolve_route(input logic        cmd_kind,
                                                    input logic [31:0] dest,
                                                    input logic [31:0] hop,
                                                    input logic [31:0] metric);
        route_result_t res;
        int unsigned   idx;
        bit            matched;
        res.status = rtul_pkg::ST_MISS;
        res.hop    = '0;
        matched    = 1'b0;
        if (cmd_kind == rtul_pkg::KIND_UPDATE)
        begin
            for (idx = 0; idx < shadow_count; idx++)
            begin
                if (shadow_dest[idx] == dest && shadow_hop[idx] == hop)
                begin
                    shadow_metric[idx] = metric;
                    matched = 1'b1;
                    break;
                end
            end
            if (matched)
                res.status = rtul_pkg::ST_UPDATED;
            else if (shadow_count < rtul_pkg::TABLE_DEPTH)
            begin
                shadow_dest[shadow_count]   = dest;
                shadow_hop[shadow_count]    = hop;
                shadow_metric[shadow_count] = metric;
                shadow_count++;
                res.status = rtul_pkg::ST_INSERTED;
            end
            else
                res.status = rtul_pkg::ST_FULL;
        end
        else
        begin
            // only the first entry with this destination counts
            for (idx = 0; idx < shadow_count; idx++)
            begin
                if (shadow_dest[idx] == dest)
                begin
                    if (shadow_hop[idx] != '0)
                    begin
                        res.status = rtul_pkg::ST_HIT;
                        res.hop    = shadow_hop[idx];
                    end
                    break;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin
        route_result_t want;
        if (rst_n !== 1'b1)
        begin
            fail_count = 0;
            pending    <= 0;
        end
        else
        begin
            // retire the result word before taking a new command word
            if (done === 1'b1)
            begin
                if (route_q.size() == 0)
                    report_mismatch("stray result word, hop_out", 'x, hop_out);
                else
                begin
                    want = route_q.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(status));
                    if (hop_out !== want.hop)
                        report_mismatch("hop_out", want.hop, hop_out);
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                route_q.push_back(resolve_route(kind, dest_addr, hop_addr, route_metric));
            pending <= route_q.size();
        end
    end

endmodule

@@ tb/tb_route_table_update_lookup.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route table update/lookup: testbench top
// Drives directed and random update and lookup words into the routing table,
// ends with deep matches and full-length misses, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_route_table_update_lookup;

    localparam int     HALF_PERIOD  = 10;
    localparam int     RANDOM_WORDS = 544;
    localparam int     TAIL_WORDS   = 12;
    localparam int     SETTLE       = rtul_pkg::TABLE_DEPTH + 8;
    localparam int     DRAIN_LIMIT  = 4 * (rtul_pkg::TABLE_DEPTH + 3);
    localparam longint TIMEOUT_NS   = 200_000_000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic        kind         = rtul_pkg::KIND_UPDATE;
    logic [31:0] dest_addr    = '0;
    logic [31:0] hop_addr     = '0;
    logic [31:0] route_metric = '0;
    logic        busy;
    logic        done;
    logic [2:0]  status;
    logic [31:0] hop_out;

    int unsigned fail_count;
    int unsigned pending;

    // pairs already sent as updates, used to aim later words at live entries
    bit          route_seen [bit [63:0]];
    logic [31:0] route_dest [$];
    logic [31:0] route_hop  [$];
    logic [31:0] hot_dest   [8];

    route_table_update_lookup uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .dest_addr    (dest_addr),
        .hop_addr     (hop_addr),
        .route_metric (route_metric),
        .done         (done),
        .status       (status),
        .hop_out      (hop_out)
    );

    route_table_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .dest_addr    (dest_addr),
        .hop_addr     (hop_addr),
        .route_metric (route_metric),
        .done         (done),
        .status       (status),
        .hop_out      (hop_out),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #(HALF_PERIOD) clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // hold start high until the word is taken; start is left high on return
    task automatic issue_word(input logic k, input logic [31:0] d,
                              input logic [31:0] h, input logic [31:0] m);
        start        <= 1'b1;
        kind         <= k;
        dest_addr    <= d;
        hop_addr     <= h;
        route_metric <= m;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (k == rtul_pkg::KIND_UPDATE && !route_seen.exists({d, h}))
        begin
            route_seen[{d, h}] = 1'b1;
            route_dest.push_back(d);
            route_hop.push_back(h);
        end
    endtask

    task automatic pick_word(output logic k, output logic [31:0] d,
                             output logic [31:0] h, output logic [31:0] m);
        int unsigned sel;
        int unsigned idx;
        sel = $urandom_range(0, 99);
        k   = rtul_pkg::KIND_UPDATE;
        d   = $urandom;
        h   = $urandom;
        m   = $urandom;
        if (sel < 30 && route_dest.size() > 0)
        begin
            // refresh the metric of a live route
            idx = $urandom_range(0, route_dest.size() - 1);
            d   = route_dest[idx];
            h   = route_hop[idx];
        end
        else if (sel < 55)
        begin
            if ($urandom_range(0, 1) == 0)
                d = hot_dest[$urandom_range(0, 7)];
            if ($urandom_range(0, 7) == 0)
                h = '0;
        end
        else if (sel < 90 && route_dest.size() > 0)
        begin
            k = rtul_pkg::KIND_LOOKUP;
            d = route_dest[$urandom_range(0, route_dest.size() - 1)];
        end
        else
        begin
            k = rtul_pkg::KIND_LOOKUP;
            if ($urandom_range(0, 1) == 0)
                d = hot_dest[$urandom_range(0, 7)];
        end
    endtask

    initial
    begin
        logic        k;
        logic [31:0] d;
        logic [31:0] h;
        logic [31:0] m;
        int          n;
        int          guard;

        hot_dest[0] = '0;
        hot_dest[1] = '1;
        for (n = 2; n < 8; n++)
            hot_dest[n] = $urandom;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, field extremes, zero next hop, first match
        issue_word(rtul_pkg::KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_word(rtul_pkg::KIND_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_word(rtul_pkg::KIND_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_word(rtul_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        issue_word(rtul_pkg::KIND_UPDATE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        issue_word(rtul_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h1234_5678, 32'h0000_0001);
        issue_word(rtul_pkg::KIND_UPDATE, 32'h0000_0000, 32'h0000_0001, 32'h0000_0005);
        issue_word(rtul_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        issue_word(rtul_pkg::KIND_UPDATE, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
        issue_word(rtul_pkg::KIND_UPDATE, 32'h0A00_0001, 32'h0A00_00FE, 32'h0000_0001);
        issue_word(rtul_pkg::KIND_UPDATE, 32'h0A00_0001, 32'h0A00_00FE, 32'h0000_0007);
        issue_word(rtul_pkg::KIND_LOOKUP, 32'h0A00_0001, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_word(rtul_pkg::KIND_UPDATE, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0002);
        issue_word(rtul_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        issue_word(rtul_pkg::KIND_LOOKUP, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000);
        issue_word(rtul_pkg::KIND_UPDATE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        issue_word(rtul_pkg::KIND_UPDATE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        issue_word(rtul_pkg::KIND_LOOKUP, 32'h5555_5555, 32'h0000_0000, 32'h0000_0000);
        issue_word(rtul_pkg::KIND_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000, 32'h0000_0000);

        // random mix with idle bursts, some after the table has gone idle
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            pick_word(k, d, h, m);
            if ($urandom_range(0, 3) == 0)
            begin
                start <= 1'b0;
                if ($urandom_range(0, 1) == 0)
                begin
                    do
                        @(posedge clk);
                    while (busy !== 1'b0);
                end
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            issue_word(k, d, h, m);
        end

        // tail, no idling: deep matches, new inserts, full-length misses
        issue_word(rtul_pkg::KIND_UPDATE, route_dest[0], route_hop[0], $urandom);
        issue_word(rtul_pkg::KIND_UPDATE, route_dest[route_dest.size() - 1],
                   route_hop[route_hop.size() - 1], 32'hFFFF_FFFF);
        issue_word(rtul_pkg::KIND_UPDATE, $urandom, $urandom, $urandom);
        issue_word(rtul_pkg::KIND_LOOKUP, route_dest[route_dest.size() - 1],
                   $urandom, $urandom);
        issue_word(rtul_pkg::KIND_LOOKUP, $urandom, $urandom, $urandom);
        for (n = 0; n < TAIL_WORDS; n++)
        begin
            pick_word(k, d, h, m);
            issue_word(k, d, h, m);
        end

        start <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
